@@ rtl/core/mf2h_pkg.sv @@
`default_nettype none

package mf2h_pkg;

  // Fixed field widths.
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 12;
  localparam int RADIUS_W  = 3;
  localparam int PWIDTH_W  = 13;
  localparam int CFG_DW    = 13;
  localparam logic [COORD_W-1:0] ROW_LIMIT = 12'hFFF;

  // Histogram: 256 bins of 8 bits, packed four bins to a memory row.
  localparam int NUM_BINS  = 256;
  localparam int BIN_W     = 8;
  localparam int LANES     = 4;
  localparam int LANE_W    = 2;
  localparam int HWORDS    = NUM_BINS / LANES;
  localparam int HIST_AW   = 6;
  localparam int HWORD_W   = BIN_W * LANES;
  localparam int ACC_W     = 16;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_RADIUS = 1'b0,
    CFG_WIDTH  = 1'b1
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LRD,
    ST_HRD,
    ST_HWR,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]   median;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
  } out_word_t;

  typedef struct packed {
    cfg_idx_t          index;
    logic [CFG_DW-1:0] value;
  } cfg_word_t;

endpackage

`default_nettype wire

@@ rtl/core/mf2h_chan_if.sv @@
`default_nettype none

// Valid/ready channel carrying one word of type T.
interface mf2h_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mf2h_ram.sv @@
`default_nettype none

// Simple dual-port RAM, one write port, one read port with registered data.
module mf2h_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/median_filter_2d_hist_8bit.sv @@
`default_nettype none

// 2-D median filter over a (2r+1)-square window for 8-bit images that are
// already padded by edge replication, one pixel per word in raster order.
// Pixels go into a line store of 2*MAX_RADIUS+1 rows; a 256-bin histogram
// of the window sits in a second RAM, four bins per row, and is updated by
// read-modify-write, through a line read, a histogram read and a histogram
// write for each bin update. When a window completes, the histogram slides one
// column (2*(2r+1) updates) or, at the first window of a row, after a frame
// start or after a register write, is rebuilt ((2r+1)^2 updates); then a scan
// of up to 64 histogram rows, one per cycle, finds the median, and the result
// word is loaded into the output register once that register is free. The
// result register lets the next pixel in while a median waits. Registers may be
// written only while idle.
module median_filter_2d_hist_8bit
  import mf2h_pkg::*;
#(
  parameter int MAX_RADIUS       = 7,
  parameter int MAX_PADDED_WIDTH = 4096
) (
  input wire logic    clk,
  input wire logic    rst_n,
  mf2h_chan_if.sink   in_s,
  mf2h_chan_if.source out_s,
  mf2h_chan_if.sink   cfg_s
);

  localparam int RING   = 2 * MAX_RADIUS + 1;
  localparam int R_W    = $clog2(MAX_RADIUS + 1);
  localparam int TR_W   = R_W + 1;
  localparam int HALF_W = 2 * TR_W;
  localparam int COL_W  = $clog2(MAX_PADDED_WIDTH);
  localparam int EW     = COL_W + 1;
  localparam int FILL_W = $clog2(RING);
  localparam int SLOT_W = $clog2(RING);
  localparam int LA_W   = $clog2(RING * MAX_PADDED_WIDTH);

  state_t state_r, state_nxt;

  // Registers and position counters.
  logic [RADIUS_W-1:0] radius_r, radius_nxt;
  logic [PWIDTH_W-1:0] pwidth_r, pwidth_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                hist_ok_r, hist_ok_nxt;
  logic [COL_W-1:0]    prev_col_r, prev_col_nxt;

  // Item being worked on.
  logic [COL_W-1:0]    it_col_r, it_col_nxt;
  logic [COORD_W-1:0]  it_row_r, it_row_nxt;
  logic [TR_W-1:0]     it_two_r, it_two_nxt;
  logic [HALF_W-1:0]   it_half_r, it_half_nxt;
  logic                slide_r, slide_nxt;

  // Update generator.
  logic [SLOT_W-1:0]   sk_r, sk_nxt;
  logic [COL_W-1:0]    cc_r, cc_nxt;
  logic [TR_W-1:0]     k_r, k_nxt;
  logic                dec_r, dec_nxt;
  logic [LANE_W-1:0]   lane_r, lane_nxt;
  logic [HIST_AW-1:0]  haddr_r, haddr_nxt;
  logic [HWORDS-1:0]   hv_r, hv_nxt;

  // Median scan.
  logic [HIST_AW:0]    scan_idx_r, scan_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [HIST_AW-1:0]  chk_idx_r, chk_idx_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [PIX_W-1:0]    med_r, med_nxt;

  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  // Memory ports.
  logic                ln_we;
  logic [LA_W-1:0]     ln_waddr, ln_raddr;
  logic [PIX_W-1:0]    ln_rdata;
  logic                h_we;
  logic [HIST_AW-1:0]  h_raddr;
  logic [HWORD_W-1:0]  h_wdata, h_rdata;

  // Accept-time decode.
  logic                in_acc;
  logic [R_W-1:0]      eff_r;
  logic [TR_W-1:0]     two_r, side;
  logic [HALF_W-1:0]   half;
  logic [EW-1:0]       eff_w, col_inc;
  logic [COL_W-1:0]    c_col;
  logic [SLOT_W-1:0]   c_slot;
  logic [FILL_W-1:0]   c_fill;
  logic [COORD_W-1:0]  c_row;
  logic                emit, slide, wrap;

  assign in_s.ready  = (state_r == ST_IDLE);
  assign cfg_s.ready = 1'b1;
  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;
  assign in_acc      = in_s.valid && (state_r == ST_IDLE);

  // Effective radius and width, and the position of the incoming pixel.
  always_comb begin
    eff_r = (32'(radius_r) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_r);
    two_r = {eff_r, 1'b0};
    side  = two_r + TR_W'(1);
    half  = HALF_W'((HALF_W'(side) * HALF_W'(side)) >> 1);
    if (pwidth_r == '0) begin
      eff_w = EW'(1);
    end else if (32'(pwidth_r) > MAX_PADDED_WIDTH) begin
      eff_w = EW'(MAX_PADDED_WIDTH);
    end else begin
      eff_w = EW'(pwidth_r);
    end
    if (in_s.data.frame_start || (32'(col_r) >= MAX_PADDED_WIDTH)) begin
      c_col = '0;
    end else begin
      c_col = col_r;
    end
    c_slot  = in_s.data.frame_start ? '0 : slot_r;
    c_fill  = in_s.data.frame_start ? '0 : fill_r;
    c_row   = in_s.data.frame_start ? '0 : row_r;
    emit    = (32'(c_fill) >= 32'(two_r)) && (32'(c_col) >= 32'(two_r));
    slide   = hist_ok_r && !in_s.data.frame_start && (c_col == prev_col_r + COL_W'(1));
    col_inc = EW'(c_col) + EW'(1);
    wrap    = (col_inc >= eff_w);
  end

  // Line store write of the incoming pixel, and the generator's read.
  assign ln_we    = in_acc;
  assign ln_waddr = LA_W'(c_slot) * LA_W'(MAX_PADDED_WIDTH) + LA_W'(c_col);
  assign ln_raddr = LA_W'(sk_r) * LA_W'(MAX_PADDED_WIDTH) + LA_W'(cc_r);
  assign h_raddr  = (state_r == ST_HRD) ? ln_rdata[PIX_W-1:LANE_W]
                                        : scan_idx_r[HIST_AW-1:0];

  // Sequencer: next state and next values.
  always_comb begin
    logic [HWORD_W-1:0] hword;
    logic [BIN_W-1:0]   bin;
    logic [ACC_W-1:0]   sum;
    logic               found;
    logic [LANE_W-1:0]  fl;

    state_nxt     = state_r;
    radius_nxt    = radius_r;
    pwidth_nxt    = pwidth_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    hist_ok_nxt   = hist_ok_r;
    prev_col_nxt  = prev_col_r;
    it_col_nxt    = it_col_r;
    it_row_nxt    = it_row_r;
    it_two_nxt    = it_two_r;
    it_half_nxt   = it_half_r;
    slide_nxt     = slide_r;
    sk_nxt        = sk_r;
    cc_nxt        = cc_r;
    k_nxt         = k_r;
    dec_nxt       = dec_r;
    lane_nxt      = lane_r;
    haddr_nxt     = haddr_r;
    hv_nxt        = hv_r;
    scan_idx_nxt  = scan_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    acc_nxt       = acc_r;
    med_nxt       = med_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    h_we          = 1'b0;
    h_wdata       = '0;
    hword         = '0;
    bin           = '0;
    sum           = acc_r;
    found         = 1'b0;
    fl            = '0;

    // The output register empties when the sink takes the word.
    if (out_valid_r && out_s.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes; they also end any sliding run.
    if (cfg_s.valid) begin
      hist_ok_nxt = 1'b0;
      unique case (cfg_s.data.index)
        CFG_RADIUS: radius_nxt = cfg_s.data.value[RADIUS_W-1:0];
        CFG_WIDTH:  pwidth_nxt = cfg_s.data.value[PWIDTH_W-1:0];
        default:    pwidth_nxt = pwidth_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          it_col_nxt  = c_col;
          it_row_nxt  = c_row;
          it_two_nxt  = two_r;
          it_half_nxt = half;
          slide_nxt   = slide;
          k_nxt       = '0;
          sk_nxt      = c_slot;
          // Advance the position counters.
          col_nxt  = wrap ? '0 : COL_W'(col_inc);
          slot_nxt = c_slot;
          fill_nxt = c_fill;
          row_nxt  = c_row;
          if (in_s.data.frame_start) begin
            hist_ok_nxt = 1'b0;
          end
          if (wrap) begin
            slot_nxt = (32'(c_slot) == RING - 1) ? '0 : c_slot + SLOT_W'(1);
            if (32'(c_fill) < 32'(two_r)) begin
              fill_nxt = c_fill + FILL_W'(1);
            end else begin
              if (32'(c_fill) > 2 * MAX_RADIUS) begin
                fill_nxt = FILL_W'(2 * MAX_RADIUS);
              end
              if (c_row < ROW_LIMIT) begin
                row_nxt = c_row + COORD_W'(1);
              end
            end
          end
          if (emit) begin
            state_nxt    = ST_LRD;
            prev_col_nxt = c_col;
            hist_ok_nxt  = !wrap;
            if (slide) begin
              dec_nxt = 1'b1;
              cc_nxt  = c_col - COL_W'(two_r) - COL_W'(1);
            end else begin
              dec_nxt = 1'b0;
              cc_nxt  = c_col - COL_W'(two_r);
              hv_nxt  = '0;
            end
          end else if (wrap) begin
            hist_ok_nxt = 1'b0;
          end
        end
      end

      ST_LRD: begin
        state_nxt = ST_HRD;
      end

      ST_HRD: begin
        lane_nxt  = ln_rdata[LANE_W-1:0];
        haddr_nxt = ln_rdata[PIX_W-1:LANE_W];
        state_nxt = ST_HWR;
      end

      ST_HWR: begin
        // Read-modify-write of one bin; rows never written read as zero.
        hword = hv_r[haddr_r] ? h_rdata : '0;
        bin   = hword[lane_r * BIN_W +: BIN_W];
        bin   = dec_r ? bin - BIN_W'(1) : bin + BIN_W'(1);
        hword[lane_r * BIN_W +: BIN_W] = bin;
        h_we    = 1'b1;
        h_wdata = hword;
        hv_nxt[haddr_r] = 1'b1;
        state_nxt = ST_LRD;
        if (slide_r) begin
          if (dec_r) begin
            dec_nxt = 1'b0;
            cc_nxt  = it_col_r;
          end else if (k_r == it_two_r) begin
            state_nxt = ST_SCAN;
          end else begin
            k_nxt   = k_r + TR_W'(1);
            sk_nxt  = (sk_r == '0) ? SLOT_W'(RING - 1) : sk_r - SLOT_W'(1);
            dec_nxt = 1'b1;
            cc_nxt  = it_col_r - COL_W'(it_two_r) - COL_W'(1);
          end
        end else begin
          if (cc_r != it_col_r) begin
            cc_nxt = cc_r + COL_W'(1);
          end else if (k_r == it_two_r) begin
            state_nxt = ST_SCAN;
          end else begin
            k_nxt  = k_r + TR_W'(1);
            sk_nxt = (sk_r == '0) ? SLOT_W'(RING - 1) : sk_r - SLOT_W'(1);
            cc_nxt = it_col_r - COL_W'(it_two_r);
          end
        end
        if (state_nxt == ST_SCAN) begin
          scan_idx_nxt = '0;
          chk_vld_nxt  = 1'b0;
          acc_nxt      = '0;
        end
      end

      ST_SCAN: begin
        // Issue one histogram row a cycle; check the row read last cycle.
        chk_vld_nxt = (scan_idx_r < (HIST_AW + 1)'(HWORDS));
        chk_idx_nxt = scan_idx_r[HIST_AW-1:0];
        if (chk_vld_nxt) begin
          scan_idx_nxt = scan_idx_r + (HIST_AW + 1)'(1);
        end
        if (chk_vld_r) begin
          hword = hv_r[chk_idx_r] ? h_rdata : '0;
          for (int l = 0; l < LANES; l++) begin
            if (!found) begin
              sum = sum + ACC_W'(hword[l * BIN_W +: BIN_W]);
              if (sum > ACC_W'(it_half_r)) begin
                found = 1'b1;
                fl    = LANE_W'(l);
              end
            end
          end
          acc_nxt = sum;
          if (found) begin
            med_nxt   = {chk_idx_r, fl};
            state_nxt = ST_OUT;
          end else if (chk_idx_r == HIST_AW'(HWORDS - 1)) begin
            med_nxt   = PIX_W'(NUM_BINS - 1);
            state_nxt = ST_OUT;
          end
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_s.ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.median  = med_r;
          out_data_nxt.out_col = COORD_W'(it_col_r - COL_W'(it_two_r));
          out_data_nxt.out_row = it_row_r;
          state_nxt            = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= RADIUS_W'(1);
      pwidth_r    <= PWIDTH_W'(4096);
      col_r       <= '0;
      row_r       <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      hist_ok_r   <= 1'b0;
      hv_r        <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      scan_idx_r  <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      pwidth_r    <= pwidth_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      hist_ok_r   <= hist_ok_nxt;
      hv_r        <= hv_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      scan_idx_r  <= scan_idx_nxt;
      k_r         <= k_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prev_col_r <= prev_col_nxt;
    it_col_r   <= it_col_nxt;
    it_row_r   <= it_row_nxt;
    it_two_r   <= it_two_nxt;
    it_half_r  <= it_half_nxt;
    slide_r    <= slide_nxt;
    sk_r       <= sk_nxt;
    cc_r       <= cc_nxt;
    dec_r      <= dec_nxt;
    lane_r     <= lane_nxt;
    haddr_r    <= haddr_nxt;
    chk_idx_r  <= chk_idx_nxt;
    acc_r      <= acc_nxt;
    med_r      <= med_nxt;
    out_data_r <= out_data_nxt;
  end

  // Line store of the last window rows.
  mf2h_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING * MAX_PADDED_WIDTH)
  ) u_line (
    .clk     (clk),
    .we      (ln_we),
    .waddr   (ln_waddr),
    .wdata   (in_s.data.pixel),
    .raddr   (ln_raddr),
    .rdata_r (ln_rdata)
  );

  // Window histogram, four bins to a row.
  mf2h_ram #(
    .WIDTH (HWORD_W),
    .DEPTH (HWORDS)
  ) u_hist (
    .clk     (clk),
    .we      (h_we),
    .waddr   (haddr_r),
    .wdata   (h_wdata),
    .raddr   (h_raddr),
    .rdata_r (h_rdata)
  );

`ifndef NO_ASSERTIONS
  // The generator never walks past the last window row.
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HWR) |-> (k_r <= it_two_r))
    else $error("histogram update beyond last window row");

  // Line reads never reach past the column of the current pixel.
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LRD) |-> (cc_r <= it_col_r))
    else $error("line read beyond current column");

  // A result appears only from the output step.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result word loaded outside the output step");

  // The scan stays within the histogram.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r <= (HIST_AW + 1)'(HWORDS)))
    else $error("median scan ran past the last bin");
`endif

endmodule

`default_nettype wire
